/* rtl/qrot_pkg.sv */
// Shared widths, types and rounding constant for the quaternion rotation pipeline.
package qrot_pkg;

    // Width of every input and output component.
    localparam int DATA_WIDTH = 32;

    // First rank: q_i * r_j, exact in twice the data width.
    localparam int PROD_W = 2 * DATA_WIDTH;
    // Components of t = r * conj(q): four products summed.
    localparam int T_W = 2 * DATA_WIDTH + 2;
    // t is split into an unsigned low slice and a signed high slice.
    localparam int LO_W = DATA_WIDTH + 1;
    localparam int HI_W = T_W - LO_W;
    // Second rank products and their sums.
    localparam int HPROD_W = HI_W + DATA_WIDTH;
    localparam int LPROD_W = LO_W + 1 + DATA_WIDTH;
    localparam int HSUM_W = HPROD_W + 1;
    localparam int LSUM_W = LPROD_W + 2;
    // Full-precision rotated component.
    localparam int RES_W = HSUM_W + LO_W;
    // The result carries 2*(DATA_WIDTH-2) fraction bits beyond the vector format.
    localparam int OUT_SHIFT = 2 * (DATA_WIDTH - 2);
    localparam int SHIFTED_W = RES_W - OUT_SHIFT;

    typedef logic signed [DATA_WIDTH-1:0] word_t;
    typedef logic signed [PROD_W-1:0]     prod_t;
    typedef logic signed [T_W-1:0]        tval_t;
    typedef logic signed [HPROD_W-1:0]    hprod_t;
    typedef logic signed [LPROD_W-1:0]    lprod_t;
    typedef logic signed [HSUM_W-1:0]     hsum_t;
    typedef logic signed [LSUM_W-1:0]     lsum_t;
    typedef logic signed [RES_W-1:0]      res_t;

    // Half an output LSB, folded into the low-slice sum for round-half-up.
    localparam lsum_t ROUND_HALF = LSUM_W'(1) <<< (OUT_SHIFT - 1);

    // Largest and smallest output values.
    localparam word_t WORD_MAX = {1'b0, {(DATA_WIDTH-1){1'b1}}};
    localparam word_t WORD_MIN = {1'b1, {(DATA_WIDTH-1){1'b0}}};

endpackage

/* rtl/qrot_conj.sv */
// Pipeline stages one and two: forms t = r * conj(q) from sixteen products.
module qrot_conj
    import qrot_pkg::*;
(
    input  logic  clk,
    input  logic  rst_n,
    input  logic  in_valid,
    output logic  in_ready,
    input  word_t q_in [4],
    input  word_t r_in [4],
    output logic  out_valid,
    input  logic  out_ready,
    output tval_t t_out [4],
    output word_t q_out [4]
);

    logic  vld1_reg;
    logic  vld2_reg;
    logic  rdy1;
    logic  rdy2;
    prod_t p_reg [4][4];
    word_t q1_reg [4];
    tval_t t_reg [4];
    word_t q2_reg [4];
    tval_t t_next [4];

    assign rdy2     = !vld2_reg || out_ready;
    assign rdy1     = !vld1_reg || rdy2;
    assign in_ready = rdy1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld1_reg <= 1'b0;
            vld2_reg <= 1'b0;
        end
        else
        begin
            if (rdy1)
            begin
                vld1_reg <= in_valid;
            end
            if (rdy2)
            begin
                vld2_reg <= vld1_reg;
            end
        end
    end

    // Product p[i][j] = q_i * r_j; the conjugate's signs are applied in the sums.
    always_ff @(posedge clk)
    begin
        if (rdy1 && in_valid)
        begin
            for (int i = 0; i < 4; i++)
            begin
                q1_reg[i] <= q_in[i];
                for (int j = 0; j < 4; j++)
                begin
                    p_reg[i][j] <= PROD_W'(q_in[i]) * PROD_W'(r_in[j]);
                end
            end
        end
    end

    always_comb
    begin
        t_next[0] = T_W'(p_reg[0][0]) + T_W'(p_reg[1][1])
                  + T_W'(p_reg[2][2]) + T_W'(p_reg[3][3]);
        t_next[1] = T_W'(p_reg[0][1]) - T_W'(p_reg[1][0])
                  + T_W'(p_reg[2][3]) - T_W'(p_reg[3][2]);
        t_next[2] = T_W'(p_reg[0][2]) - T_W'(p_reg[2][0])
                  + T_W'(p_reg[3][1]) - T_W'(p_reg[1][3]);
        t_next[3] = T_W'(p_reg[0][3]) - T_W'(p_reg[3][0])
                  + T_W'(p_reg[1][2]) - T_W'(p_reg[2][1]);
    end

    always_ff @(posedge clk)
    begin
        if (rdy2 && vld1_reg)
        begin
            for (int i = 0; i < 4; i++)
            begin
                t_reg[i]  <= t_next[i];
                q2_reg[i] <= q1_reg[i];
            end
        end
    end

    assign out_valid = vld2_reg;
    assign t_out     = t_reg;
    assign q_out     = q2_reg;

endmodule

/* rtl/qrot_apply.sv */
// Pipeline stages three and four: partial products of q * t over split t, then sums.
module qrot_apply
    import qrot_pkg::*;
(
    input  logic  clk,
    input  logic  rst_n,
    input  logic  in_valid,
    output logic  in_ready,
    input  tval_t t_in [4],
    input  word_t q_in [4],
    output logic  out_valid,
    input  logic  out_ready,
    output hsum_t hs_out [4],
    output lsum_t ls_out [4]
);

    logic   vld3_reg;
    logic   vld4_reg;
    logic   rdy3;
    logic   rdy4;
    hprod_t hp_reg [4][4];
    lprod_t lp_reg [4][4];
    hsum_t  hs_reg [4];
    lsum_t  ls_reg [4];
    hsum_t  hs_next [4];
    lsum_t  ls_next [4];

    assign rdy4     = !vld4_reg || out_ready;
    assign rdy3     = !vld3_reg || rdy4;
    assign in_ready = rdy3;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld3_reg <= 1'b0;
            vld4_reg <= 1'b0;
        end
        else
        begin
            if (rdy3)
            begin
                vld3_reg <= in_valid;
            end
            if (rdy4)
            begin
                vld4_reg <= vld3_reg;
            end
        end
    end

    // Entry [i][j] holds t_i * q_j, split into a signed high and an unsigned low slice.
    always_ff @(posedge clk)
    begin
        if (rdy3 && in_valid)
        begin
            for (int i = 0; i < 4; i++)
            begin
                for (int j = 0; j < 4; j++)
                begin
                    hp_reg[i][j] <= HPROD_W'($signed(t_in[i][T_W-1:LO_W]))
                                  * HPROD_W'(q_in[j]);
                    lp_reg[i][j] <= LPROD_W'($signed({1'b0, t_in[i][LO_W-1:0]}))
                                  * LPROD_W'(q_in[j]);
                end
            end
        end
    end

    always_comb
    begin
        hs_next[0] = HSUM_W'(hp_reg[0][0]) - HSUM_W'(hp_reg[1][1])
                   - HSUM_W'(hp_reg[2][2]) - HSUM_W'(hp_reg[3][3]);
        hs_next[1] = HSUM_W'(hp_reg[1][0]) + HSUM_W'(hp_reg[0][1])
                   + HSUM_W'(hp_reg[3][2]) - HSUM_W'(hp_reg[2][3]);
        hs_next[2] = HSUM_W'(hp_reg[2][0]) + HSUM_W'(hp_reg[0][2])
                   + HSUM_W'(hp_reg[1][3]) - HSUM_W'(hp_reg[3][1]);
        hs_next[3] = HSUM_W'(hp_reg[3][0]) + HSUM_W'(hp_reg[0][3])
                   + HSUM_W'(hp_reg[2][1]) - HSUM_W'(hp_reg[1][2]);

        ls_next[0] = ROUND_HALF + LSUM_W'(lp_reg[0][0]) - LSUM_W'(lp_reg[1][1])
                   - LSUM_W'(lp_reg[2][2]) - LSUM_W'(lp_reg[3][3]);
        ls_next[1] = ROUND_HALF + LSUM_W'(lp_reg[1][0]) + LSUM_W'(lp_reg[0][1])
                   + LSUM_W'(lp_reg[3][2]) - LSUM_W'(lp_reg[2][3]);
        ls_next[2] = ROUND_HALF + LSUM_W'(lp_reg[2][0]) + LSUM_W'(lp_reg[0][2])
                   + LSUM_W'(lp_reg[1][3]) - LSUM_W'(lp_reg[3][1]);
        ls_next[3] = ROUND_HALF + LSUM_W'(lp_reg[3][0]) + LSUM_W'(lp_reg[0][3])
                   + LSUM_W'(lp_reg[2][1]) - LSUM_W'(lp_reg[1][2]);
    end

    always_ff @(posedge clk)
    begin
        if (rdy4 && vld3_reg)
        begin
            for (int i = 0; i < 4; i++)
            begin
                hs_reg[i] <= hs_next[i];
                ls_reg[i] <= ls_next[i];
            end
        end
    end

    assign out_valid = vld4_reg;
    assign hs_out    = hs_reg;
    assign ls_out    = ls_reg;

endmodule

/* rtl/qrot_round.sv */
// Pipeline stages five and six: recombines the slices, then rounds and saturates.
module qrot_round
    import qrot_pkg::*;
(
    input  logic  clk,
    input  logic  rst_n,
    input  logic  in_valid,
    output logic  in_ready,
    input  hsum_t hs_in [4],
    input  lsum_t ls_in [4],
    output logic  out_valid,
    input  logic  out_ready,
    output word_t res_out [4]
);

    logic  vld5_reg;
    logic  vld6_reg;
    logic  rdy5;
    logic  rdy6;
    res_t  v_reg [4];
    word_t res_reg [4];
    word_t res_next [4];
    logic [SHIFTED_W-1:0] shifted [4];
    logic [SHIFTED_W-DATA_WIDTH:0] top_bits [4];

    assign rdy6     = !vld6_reg || out_ready;
    assign rdy5     = !vld5_reg || rdy6;
    assign in_ready = rdy5;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld5_reg <= 1'b0;
            vld6_reg <= 1'b0;
        end
        else
        begin
            if (rdy5)
            begin
                vld5_reg <= in_valid;
            end
            if (rdy6)
            begin
                vld6_reg <= vld5_reg;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (rdy5 && in_valid)
        begin
            for (int i = 0; i < 4; i++)
            begin
                v_reg[i] <= (RES_W'(hs_in[i]) <<< LO_W) + RES_W'(ls_in[i]);
            end
        end
    end

    // The rounding half is already in; dropping the fraction floors the value.
    always_comb
    begin
        for (int i = 0; i < 4; i++)
        begin
            shifted[i]  = v_reg[i][RES_W-1:OUT_SHIFT];
            top_bits[i] = shifted[i][SHIFTED_W-1:DATA_WIDTH-1];
            if ((&top_bits[i]) || !(|top_bits[i]))
            begin
                res_next[i] = word_t'(shifted[i][DATA_WIDTH-1:0]);
            end
            else if (shifted[i][SHIFTED_W-1])
            begin
                res_next[i] = WORD_MIN;
            end
            else
            begin
                res_next[i] = WORD_MAX;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (rdy6 && vld5_reg)
        begin
            for (int i = 0; i < 4; i++)
            begin
                res_reg[i] <= res_next[i];
            end
        end
    end

    assign out_valid = vld6_reg;
    assign res_out   = res_reg;

endmodule

/* rtl/quaternion_rotate.sv */
// Top level of the quaternion rotation pipeline: q * r * conj(q), rounded and saturated.
//
//   Channel   Direction  Handshake             Beat contents
//   input     in         in_valid / in_ready   rot_w..rot_z (Q2.30), vec_w..vec_z (Q16.16)
//   output    out        out_valid / out_ready out_w..out_z (Q16.16, saturated)
//
// A beat passes six registered stages from input to output; a new beat is taken every
// cycle unless the output stalls. The stages are the two multiplier ranks, each followed
// by its adder stage, then the wide recombining add and the round and saturate stage.
// Reset clears only the six stage valid bits; the datapath registers are not reset.
// When out_ready is low the pipeline fills its empty stages first, so input beats
// are still taken until every stage holds one; nothing is dropped or issued twice.
module quaternion_rotate
    import qrot_pkg::*;
(
    input  logic  clk,
    input  logic  rst_n,
    input  logic  in_valid,
    output logic  in_ready,
    input  word_t rot_w,
    input  word_t rot_x,
    input  word_t rot_y,
    input  word_t rot_z,
    input  word_t vec_w,
    input  word_t vec_x,
    input  word_t vec_y,
    input  word_t vec_z,
    output logic  out_valid,
    input  logic  out_ready,
    output word_t out_w,
    output word_t out_x,
    output word_t out_y,
    output word_t out_z
);

    word_t q_in [4];
    word_t r_in [4];

    // Between the conjugate-product stages and the second product stages.
    logic  conj_valid;
    logic  conj_ready;
    tval_t t_val [4];
    word_t q_val [4];

    // Between the second product stages and the round stages.
    logic  apply_valid;
    logic  apply_ready;
    hsum_t hs_val [4];
    lsum_t ls_val [4];

    word_t res [4];

    assign q_in[0] = rot_w;
    assign q_in[1] = rot_x;
    assign q_in[2] = rot_y;
    assign q_in[3] = rot_z;
    assign r_in[0] = vec_w;
    assign r_in[1] = vec_x;
    assign r_in[2] = vec_y;
    assign r_in[3] = vec_z;

    // First Hamilton product, t = r * conj(q).
    qrot_conj u_conj
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .q_in      (q_in),
        .r_in      (r_in),
        .out_valid (conj_valid),
        .out_ready (conj_ready),
        .t_out     (t_val),
        .q_out     (q_val)
    );

    // Second Hamilton product, q * t, with t split so each multiplier stays narrow.
    qrot_apply u_apply
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (conj_valid),
        .in_ready  (conj_ready),
        .t_in      (t_val),
        .q_in      (q_val),
        .out_valid (apply_valid),
        .out_ready (apply_ready),
        .hs_out    (hs_val),
        .ls_out    (ls_val)
    );

    // Recombination, round to nearest with ties upwards, and saturation.
    qrot_round u_round
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (apply_valid),
        .in_ready  (apply_ready),
        .hs_in     (hs_val),
        .ls_in     (ls_val),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .res_out   (res)
    );

    assign out_w = res[0];
    assign out_x = res[1];
    assign out_y = res[2];
    assign out_z = res[3];

    // A draining output always leaves room for a new input beat.
    assert property (@(posedge clk) disable iff (!rst_n) out_ready |-> in_ready)
        else $error("input stalled while output drains");

    // The input can only be held off when the output stage is full and stalled.
    assert property (@(posedge clk) disable iff (!rst_n)
                     !in_ready |-> (out_valid && !out_ready))
        else $error("input stalled without output back-pressure");

    // No result is offered in the cycle after reset has been seen low.
    assert property (@(posedge clk) !rst_n |=> !out_valid)
        else $error("output valid after reset");

endmodule
